@@ rtl/core/bilinear_table_interpolator_core_defines.svh @@
// Assertion macros used by the checker file.
`ifndef BILINEAR_TABLE_INTERPOLATOR_CORE_DEFINES_SVH
`define BILINEAR_TABLE_INTERPOLATOR_CORE_DEFINES_SVH

// Assertion checked at every rising edge.
`define BTI_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// Assertion switched off while reset is high.
`define BTI_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ rtl/core/bti_pkg.sv @@
package bti_pkg;

   localparam int MAX_ROWS = 8;
   localparam int MAX_COLS = 8;
   localparam int ROW_W    = 3;
   localparam int COL_W    = 3;
   localparam int CNT_W    = 4;
   localparam int GRID_AW  = $clog2(MAX_ROWS * MAX_COLS);
   localparam int FRAC_W   = 17;
   localparam int DIV_STEPS = FRAC_W;

   typedef enum logic [1:0] {
      MODE_SLEW  = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_GRID  = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   typedef struct packed {
      mode_type           mode;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic signed [31:0] wdata;
      logic signed [31:0] slew_in;
      logic signed [31:0] load_in;
   } item_type;

   // Item as classified by the front end.
   typedef struct packed {
      logic     query;
      logic     wr_ok;
      item_type item;
   } entry_type;

   // Count in use: zero acts as one, above the maximum acts as the maximum.
   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] lim);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > lim) begin
         r = lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

@@ rtl/core/bti_front.sv @@
module bti_front import bti_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   output logic      full,
   input  item_type  item,
   output logic      q_valid,
   output entry_type q_entry,
   input  logic      q_pop
);

   entry_type  fifo_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   entry_type  entry_in;
   logic       push_ok;
   logic       pop_ok;

   always_comb begin
      entry_in.item  = item;
      entry_in.query = (item.mode == MODE_QUERY);
      unique case (item.mode)
         MODE_SLEW:  entry_in.wr_ok = (int'(item.row) < MAX_ROWS);
         MODE_LOAD:  entry_in.wr_ok = (int'(item.col) < MAX_COLS);
         MODE_GRID:  entry_in.wr_ok = (int'(item.row) < MAX_ROWS) &&
                                      (int'(item.col) < MAX_COLS);
         MODE_QUERY: entry_in.wr_ok = 1'b0;
         default:    entry_in.wr_ok = 1'b0;
      endcase
   end

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_entry = fifo_ff[rd_ptr_ff];
   assign push_ok = push && !full;
   assign pop_ok  = q_pop && q_valid;

   always_ff @(posedge clock) begin
      if (push_ok) begin
         fifo_ff[wr_ptr_ff] <= entry_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_ok) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         priority if (push_ok && !pop_ok) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop_ok && !push_ok) begin
            count_ff <= count_ff - 2'd1;
         end else begin
            count_ff <= count_ff;
         end
      end
   end

endmodule

@@ rtl/core/bti_back.sv @@
module bti_back import bti_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wen,
   input  logic               csr_index,
   input  logic [CNT_W-1:0]   csr_wdata,
   input  logic               q_valid,
   input  entry_type          q_entry,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_result
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FIRST, ST_LAST, ST_SCAN, ST_DIV, ST_NEXT,
      ST_GRID, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_DONE
   } state_type;

   localparam logic signed [50:0] SAT_HI = 51'sd2147483647;
   localparam logic signed [50:0] SAT_LO = -51'sd2147483648;

   state_type          state_ff;
   logic [CNT_W-1:0]   rows_ff, cols_ff;
   logic signed [31:0] slew_ax_ff [MAX_ROWS];
   logic signed [31:0] load_ax_ff [MAX_COLS];
   logic signed [31:0] grid_mem [MAX_ROWS*MAX_COLS];
   logic signed [31:0] grid_rd_ff;
   logic signed [31:0] xs_ff, xl_ff, prev_ff;
   logic               sel_ff;
   logic [ROW_W-1:0]   idx_ff, lo_ff, hi_ff, i0_ff, i1_ff;
   logic [COL_W-1:0]   j0_ff, j1_ff;
   logic [31:0]        den_ff;
   logic [32:0]        rem_ff;
   logic [FRAC_W-1:0]  quo_ff, ts_ff, tl_ff;
   logic [4:0]         cnt_ff;
   logic [2:0]         rd_cnt_ff;
   logic signed [31:0] g_ff [4];
   logic signed [50:0] prod_ff;
   logic signed [32:0] v0_ff, v1_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_data_ff;

   logic [CNT_W-1:0]   n_use;
   logic [ROW_W-1:0]   last_idx, ax_addr;
   logic signed [31:0] x_cur, ax_rd;
   logic signed [32:0] num_c, den_c;
   logic               hit;
   logic [32:0]        rem_sh, rem_in;
   logic               ge;
   logic [FRAC_W-1:0]  quo_in;
   logic [GRID_AW-1:0] grid_waddr, grid_raddr;
   logic               grid_we;
   logic signed [32:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [50:0] prod_in, prod_sh, sum_c;
   logic signed [32:0] v_in;
   logic signed [31:0] res_in;

   always_comb begin
      n_use    = sel_ff ? clamp_count(cols_ff, CNT_W'(MAX_COLS))
                        : clamp_count(rows_ff, CNT_W'(MAX_ROWS));
      last_idx = ROW_W'(n_use - CNT_W'(1));
      x_cur    = sel_ff ? xl_ff : xs_ff;
      unique case (state_ff)
         ST_LAST: ax_addr = last_idx;
         ST_SCAN: ax_addr = idx_ff;
         default: ax_addr = '0;
      endcase
      ax_rd = sel_ff ? load_ax_ff[ax_addr] : slew_ax_ff[ax_addr];
      hit   = (prev_ff <= x_cur) && (x_cur <= ax_rd);
      num_c = 33'(x_cur) - 33'(prev_ff);
      den_c = 33'(ax_rd) - 33'(prev_ff);
   end

   // One quotient bit per cycle; the first step takes no shift.
   always_comb begin
      rem_sh = (cnt_ff == 5'(DIV_STEPS)) ? rem_ff : {rem_ff[31:0], 1'b0};
      ge     = (rem_sh >= {1'b0, den_ff});
      rem_in = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
      quo_in = {quo_ff[FRAC_W-2:0], ge};
   end

   always_comb begin
      unique case (rd_cnt_ff[1:0])
         2'd0:    grid_raddr = GRID_AW'(int'(i0_ff) * MAX_COLS + int'(j0_ff));
         2'd1:    grid_raddr = GRID_AW'(int'(i0_ff) * MAX_COLS + int'(j1_ff));
         2'd2:    grid_raddr = GRID_AW'(int'(i1_ff) * MAX_COLS + int'(j0_ff));
         default: grid_raddr = GRID_AW'(int'(i1_ff) * MAX_COLS + int'(j1_ff));
      endcase
      grid_waddr = GRID_AW'(int'(q_entry.item.row) * MAX_COLS + int'(q_entry.item.col));
      grid_we    = (state_ff == ST_IDLE) && q_valid && q_entry.wr_ok &&
                   (q_entry.item.mode == MODE_GRID);
   end

   // Shared multiplier: difference times fraction.
   always_comb begin
      unique case (state_ff)
         ST_MUL0: begin
            mul_a = 33'(g_ff[1]) - 33'(g_ff[0]);
            mul_b = {1'b0, tl_ff};
         end
         ST_MUL1: begin
            mul_a = 33'(g_ff[3]) - 33'(g_ff[2]);
            mul_b = {1'b0, tl_ff};
         end
         default: begin
            mul_a = v1_ff - v0_ff;
            mul_b = {1'b0, ts_ff};
         end
      endcase
      prod_in = 51'(mul_a) * 51'(mul_b);
      prod_sh = prod_ff >>> 16;
      unique case (state_ff)
         ST_MUL1: sum_c = 51'(g_ff[0]) + prod_sh;
         ST_MUL2: sum_c = 51'(g_ff[2]) + prod_sh;
         default: sum_c = 51'(v0_ff) + prod_sh;
      endcase
      v_in = 33'(sum_c);
      priority if (sum_c > SAT_HI) begin
         res_in = 32'sh7FFF_FFFF;
      end else if (sum_c < SAT_LO) begin
         res_in = 32'sh8000_0000;
      end else begin
         res_in = 32'(sum_c);
      end
   end

   assign q_pop      = (state_ff == ST_IDLE) && q_valid;
   assign rsp_empty  = !rsp_valid_ff;
   assign rsp_result = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[grid_waddr] <= q_entry.item.wdata;
      end
      grid_rd_ff <= grid_mem[grid_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= CNT_W'(1);
         cols_ff      <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               CSR_ROWS: rows_ff <= csr_wdata;
               CSR_COLS: cols_ff <= csr_wdata;
               default:  rows_ff <= rows_ff;
            endcase
         end
         // in the done state the result register is handled below
         if (rsp_pop && rsp_valid_ff && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  if (q_entry.query) begin
                     xs_ff    <= q_entry.item.slew_in;
                     xl_ff    <= q_entry.item.load_in;
                     sel_ff   <= 1'b0;
                     state_ff <= ST_FIRST;
                  end else if (q_entry.wr_ok) begin
                     if (q_entry.item.mode == MODE_SLEW) begin
                        slew_ax_ff[q_entry.item.row] <= q_entry.item.wdata;
                     end
                     if (q_entry.item.mode == MODE_LOAD) begin
                        load_ax_ff[q_entry.item.col] <= q_entry.item.wdata;
                     end
                  end
               end
            end
            ST_FIRST: begin
               if (x_cur <= ax_rd) begin
                  lo_ff    <= '0;
                  hi_ff    <= '0;
                  quo_ff   <= '0;
                  state_ff <= ST_NEXT;
               end else begin
                  prev_ff  <= ax_rd;
                  state_ff <= ST_LAST;
               end
            end
            ST_LAST: begin
               if (x_cur >= ax_rd) begin
                  lo_ff    <= last_idx;
                  hi_ff    <= last_idx;
                  quo_ff   <= '0;
                  state_ff <= ST_NEXT;
               end else begin
                  idx_ff   <= ROW_W'(1);
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (hit) begin
                  lo_ff  <= idx_ff - ROW_W'(1);
                  hi_ff  <= idx_ff;
                  rem_ff <= {1'b0, num_c[31:0]};
                  den_ff <= den_c[31:0];
                  quo_ff <= '0;
                  cnt_ff <= 5'(DIV_STEPS);
                  state_ff <= (den_c == '0) ? ST_NEXT : ST_DIV;
               end else if (idx_ff == last_idx) begin
                  // no bracket: fall back to the first point
                  lo_ff    <= '0;
                  hi_ff    <= '0;
                  quo_ff   <= '0;
                  state_ff <= ST_NEXT;
               end else begin
                  prev_ff <= ax_rd;
                  idx_ff  <= idx_ff + ROW_W'(1);
               end
            end
            ST_DIV: begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd1) begin
                  state_ff <= ST_NEXT;
               end
            end
            ST_NEXT: begin
               if (!sel_ff) begin
                  i0_ff    <= lo_ff;
                  i1_ff    <= hi_ff;
                  ts_ff    <= quo_ff;
                  sel_ff   <= 1'b1;
                  state_ff <= ST_FIRST;
               end else begin
                  j0_ff     <= COL_W'(lo_ff);
                  j1_ff     <= COL_W'(hi_ff);
                  tl_ff     <= quo_ff;
                  rd_cnt_ff <= '0;
                  state_ff  <= ST_GRID;
               end
            end
            ST_GRID: begin
               // read data arrives in the cycle after its address
               if (rd_cnt_ff != 3'd0) begin
                  g_ff[2'(rd_cnt_ff - 3'd1)] <= grid_rd_ff;
               end
               rd_cnt_ff <= rd_cnt_ff + 3'd1;
               if (rd_cnt_ff == 3'd4) begin
                  state_ff <= ST_MUL0;
               end
            end
            ST_MUL0: begin
               prod_ff  <= prod_in;
               state_ff <= ST_MUL1;
            end
            ST_MUL1: begin
               v0_ff    <= v_in;
               prod_ff  <= prod_in;
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               v1_ff    <= v_in;
               state_ff <= ST_MUL3;
            end
            ST_MUL3: begin
               prod_ff  <= prod_in;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               // hold until the result register is free
               if (!rsp_valid_ff || rsp_pop) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/core/bilinear_table_interpolator_core.sv @@
// Writes are handled in the back end's idle state. A query, per axis, scans up
// to n points for a bracket and runs a restoring divider, then reads 4 grid
// points and runs 4 multiply steps on one multiplier.
// A two-entry input queue and a one-entry result register decouple both sides.
// Synchronous active-high reset empties both queues and sets both counts to 1;
// axis and grid contents are not cleared.
module bilinear_table_interpolator_core import bti_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_mode,
   input  logic [ROW_W-1:0]   req_row,
   input  logic [COL_W-1:0]   req_col,
   input  logic signed [31:0] req_wdata,
   input  logic signed [31:0] req_slew_in,
   input  logic signed [31:0] req_load_in,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_result,
   input  logic               csr_wen,
   input  logic               csr_index,
   input  logic [CNT_W-1:0]   csr_wdata
);

   item_type  item;
   entry_type q_entry;
   logic      q_valid;
   logic      q_pop;

   always_comb begin
      item.mode    = mode_type'(req_mode);
      item.row     = req_row;
      item.col     = req_col;
      item.wdata   = req_wdata;
      item.slew_in = req_slew_in;
      item.load_in = req_load_in;
   end

   bti_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .item    (item),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop)
   );

   bti_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_result (rsp_result)
   );

endmodule

@@ rtl/core/bti_checker.sv @@
`include "bilinear_table_interpolator_core_defines.svh"

module bti_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_result
);

   `BTI_ASSERT(a_rsp_empty_after_reset, clock, reset |=> rsp_empty, "result after reset")
   `BTI_ASSERT(a_queue_open_after_reset, clock, reset |=> !req_full, "queue full after reset")
   `BTI_ASSERT_RST(a_rsp_held, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_result)), "waiting result changed")

endmodule

bind bilinear_table_interpolator_core bti_checker u_bti_checker (.*);
